FILE: rtl/ordered_list_positional_delete_macros.svh
// ----------------------------------------------------------------------------
// Ordered list positional delete - assertion macros
// Concurrent checks sampled on clk, masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITIONAL_DELETE_MACROS_SVH
`define ORDERED_LIST_POSITIONAL_DELETE_MACROS_SVH

// same-cycle implication
`define OLPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olpd assertion failed");

// next-cycle implication
`define OLPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olpd assertion failed");

`endif

FILE: rtl/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg
// Types and constants shared by the ordered list positional delete block.
// ----------------------------------------------------------------------------
package olpd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_DEL_FIRST = 2'd1,
    KIND_DEL_POS   = 2'd2,
    KIND_DEL_LAST  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic        [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // per-cell strobes from the list controller
  typedef struct packed {
    logic shift;  // take the neighbour's word
    logic load;   // take the appended word
  } cell_ctl_t;

endpackage

FILE: rtl/olpd_cell.sv
// ----------------------------------------------------------------------------
// olpd_cell
// One slot of the list: holds a word, loads an appended word or takes the
// word of the next slot when the entry in it or ahead of it is deleted.
// ----------------------------------------------------------------------------
module olpd_cell #(
  parameter int DATA_WIDTH = olpd_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  olpd_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0]  app_word,
  input  logic [DATA_WIDTH-1:0]  nbr_word,
  output logic [DATA_WIDTH-1:0]  word
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = nbr_word;
    end else if (ctl.load) begin
      data_nxt = app_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word = data_r;

endmodule

FILE: rtl/ordered_list_positional_delete.sv
// A result strobes on out_valid in the cycle after start is taken.
// Throughput: one operation per cycle once busy drops; the row of cells
// shifts every entry behind a deleted slot in the same cycle.
// Reset: synchronous, active low; clears the count and the result strobe,
// busy reads high during reset and drops at the first edge with rst_n high.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// ordered_list_positional_delete
// Ordered list of up to DEPTH signed words with append and head, tail and
// positional delete, built as a row of shifting cells.
// ----------------------------------------------------------------------------
module ordered_list_positional_delete #(
  parameter int DEPTH      = olpd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = olpd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olpd_pkg::in_item_t  in_item,
  output logic                out_valid,
  output olpd_pkg::out_item_t out_result
);

  `include "ordered_list_positional_delete_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > olpd_pkg::POS_W) ? CW : olpd_pkg::POS_W;

  logic [CW-1:0]          occ_r;
  logic [CW-1:0]          occ_nxt;
  logic                   busy_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  olpd_pkg::out_item_t    out_result_r;
  olpd_pkg::out_item_t    out_result_nxt;

  logic                   accept;
  logic                   do_del;
  logic                   do_app;
  logic [IW-1:0]          del_idx;
  olpd_pkg::status_t      status;
  logic [PW-1:0]          pos_x;
  logic [PW-1:0]          occ_x;
  logic [DATA_WIDTH-1:0]  app_word;
  logic [DATA_WIDTH-1:0]  rd_word;

  logic [DATA_WIDTH-1:0]  cell_q [DEPTH];
  olpd_pkg::cell_ctl_t    cell_ctl [DEPTH];

  assign accept   = start && !busy_r;
  assign pos_x    = PW'(in_item.position);
  assign occ_x    = PW'(occ_r);
  assign app_word = DATA_WIDTH'(in_item.value);

  // decode the request against the current count
  always_comb begin
    do_del  = 1'b0;
    do_app  = 1'b0;
    del_idx = '0;
    status  = olpd_pkg::ST_DONE;
    if (in_item.kind == olpd_pkg::KIND_APPEND) begin
      if (occ_r >= CW'(DEPTH)) begin
        status = olpd_pkg::ST_FULL;
      end else begin
        do_app = 1'b1;
      end
    end else if (occ_r == '0) begin
      status = olpd_pkg::ST_EMPTY;
    end else begin
      case (in_item.kind)
        olpd_pkg::KIND_DEL_FIRST: begin
          do_del = 1'b1;
        end
        olpd_pkg::KIND_DEL_LAST: begin
          do_del  = 1'b1;
          del_idx = IW'(occ_r - CW'(1));
        end
        olpd_pkg::KIND_DEL_POS: begin
          // a lone entry goes whatever position was asked for
          if (occ_r == CW'(1)) begin
            do_del = 1'b1;
          end else if (pos_x == '0 || pos_x > occ_x) begin
            status = olpd_pkg::ST_BADPOS;
          end else begin
            do_del  = 1'b1;
            del_idx = IW'(pos_x - PW'(1));
          end
        end
        default: begin
          status = olpd_pkg::ST_DONE;
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = cell_q[gi];
      end else begin : g_mid
        assign nbr = cell_q[gi + 1];
      end

      assign cell_ctl[gi].shift = accept && do_del && (CW'(gi) >= CW'(del_idx))
                                  && (CW'(gi + 1) < occ_r);
      assign cell_ctl[gi].load  = accept && do_app && (occ_r == CW'(gi));

      olpd_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[gi]),
        .app_word (app_word),
        .nbr_word (nbr),
        .word     (cell_q[gi])
      );
    end
  endgenerate

  assign rd_word = cell_q[del_idx];

  always_comb begin
    occ_nxt = occ_r;
    if (accept && do_app) begin
      occ_nxt = occ_r + CW'(1);
    end else if (accept && do_del) begin
      occ_nxt = occ_r - CW'(1);
    end
    out_valid_nxt                = accept;
    out_result_nxt               = out_result_r;
    if (accept) begin
      out_result_nxt.status        = status;
      out_result_nxt.removed_value = do_del ? olpd_pkg::VALUE_W'($signed(rd_word)) : '0;
      out_result_nxt.entry_count   = olpd_pkg::COUNT_W'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      busy_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `OLPD_ASSERT_NEXT(a_beat_strobes, accept, out_valid)
  `OLPD_ASSERT_NEXT(a_no_spurious_beat, !accept, !out_valid)
  `OLPD_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= CW'(DEPTH))
  `OLPD_ASSERT_SAME(a_refused_keeps_count,
                    out_valid && out_result.status != olpd_pkg::ST_DONE,
                    occ_r == $past(occ_r))

endmodule

FILE: tb/olpd_list_checker.sv
// ----------------------------------------------------------------------------
// olpd_list_checker
// Watches the operation and result channels of the ordered list, keeps its own
// copy of the list, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module olpd_list_checker
  import olpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_result,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] list_words [DEPTH_DEF];
  logic        [COUNT_W-1:0] list_count;
  out_item_t                 expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_count = '0;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // applies one operation to the shadow list and returns the result beat
  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t res;
    int        slot;
    res.status        = ST_DONE;
    res.removed_value = '0;
    slot              = -1;
    if (op.kind == KIND_APPEND) begin
      if (list_count >= DEPTH_DEF) begin
        res.status = ST_FULL;
      end else begin
        list_words[list_count] = op.value;
        list_count++;
      end
    end else if (list_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      case (op.kind)
        KIND_DEL_FIRST: slot = 0;
        KIND_DEL_LAST:  slot = list_count - 1;
        default: begin
          // a lone entry goes whatever the position says
          if (list_count == 1)
            slot = 0;
          else if (op.position == 0 || op.position > list_count)
            res.status = ST_BADPOS;
          else
            slot = op.position - 1;
        end
      endcase
    end
    if (slot >= 0) begin
      res.removed_value = list_words[slot];
      for (int i = slot; i + 1 < list_count; i++)
        list_words[i] = list_words[i + 1];
      list_count--;
    end
    res.entry_count = list_count;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_count = '0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_result.removed_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_result.status !== want.status)
            report("status", 32'(out_result.status), 32'(want.status));
          if (out_result.removed_value !== want.removed_value)
            report("removed_value", out_result.removed_value, want.removed_value);
          if (out_result.entry_count !== want.entry_count)
            report("entry_count", 32'(out_result.entry_count), 32'(want.entry_count));
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_list_op(in_item));
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives list operations into the ordered list in random bursts: a directed
// opening over the corner cases, then phases that fill, drain and churn the
// list. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import olpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS = 1550;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_result;
  int        fail_count;
  int        pending;

  ordered_list_positional_delete u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  olpd_list_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic in_item_t mk_op(kind_t kind, logic [31:0] value, logic [4:0] position);
    in_item_t op;
    op.kind     = kind;
    op.value    = value;
    op.position = position;
    return op;
  endfunction

  // mode 0 leans to appends, 1 to deletes, 2 is even
  function automatic in_item_t rand_op(int mode);
    in_item_t    op;
    int          roll;
    int          append_pct;
    logic [31:0] extremes [4];
    extremes   = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
    append_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
    roll       = $urandom_range(0, 99);
    if (roll < append_pct)
      op.kind = KIND_APPEND;
    else
      op.kind = kind_t'($urandom_range(1, 3));
    op.value = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 3)] : $urandom;
    // mostly in range, now and then zero or past the end
    if ($urandom_range(0, 99) < 10)
      op.position = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
    else
      op.position = 5'($urandom_range(1, DEPTH_DEF));
    return op;
  endfunction

  // start is left high so back-to-back beats need no extra edge
  task automatic send_op(in_item_t op);
    start   <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int gap;
    if ($urandom_range(0, 3) != 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_item_t directed [$];
    int       sent;
    int       burst;
    int       mode;
    int       phase_left;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      mk_op(KIND_DEL_FIRST, 32'h0,         5'd1),   // deletes on an empty list
      mk_op(KIND_DEL_POS,   32'h0,         5'd1),
      mk_op(KIND_DEL_LAST,  32'h0,         5'd31),
      mk_op(KIND_APPEND,    32'h7fff_ffff, 5'd0),
      mk_op(KIND_DEL_POS,   32'h0,         5'd0),   // lone entry, position zero
      mk_op(KIND_APPEND,    32'h8000_0000, 5'd31),
      mk_op(KIND_DEL_POS,   32'h0,         5'd31),  // lone entry, far position
      mk_op(KIND_APPEND,    32'h0000_0000, 5'd0),
      mk_op(KIND_APPEND,    32'hffff_ffff, 5'd0),
      mk_op(KIND_APPEND,    32'h1234_5678, 5'd0),
      mk_op(KIND_DEL_POS,   32'h0,         5'd0),   // refused positions
      mk_op(KIND_DEL_POS,   32'h0,         5'd4),
      mk_op(KIND_DEL_POS,   32'h0,         5'd16),
      mk_op(KIND_DEL_POS,   32'h0,         5'd2),   // middle
      mk_op(KIND_APPEND,    32'h8000_0001, 5'd0),
      mk_op(KIND_APPEND,    32'h7fff_fffe, 5'd0),
      mk_op(KIND_DEL_POS,   32'h0,         5'd4),   // tail by position
      mk_op(KIND_DEL_FIRST, 32'hffff_ffff, 5'd31),
      mk_op(KIND_DEL_LAST,  32'h5a5a_5a5a, 5'd7),
      mk_op(KIND_DEL_POS,   32'h0,         5'd1),
      mk_op(KIND_DEL_LAST,  32'h0,         5'd0)
    };
    foreach (directed[i]) send_op(directed[i]);
    idle_gap();

    sent       = 0;
    mode       = 0;
    phase_left = 0;
    while (sent < RANDOM_OPS) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < RANDOM_OPS; b++) begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(40, 120);
        end
        send_op(rand_op(mode));
        phase_left--;
        sent++;
      end
      idle_gap();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
